// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/mswg_pkg.sv -----
// ----------------------------------------------------------------------------
// mswg_pkg
// Types, register indexes and the quarter-wave sine table for the generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mswg_pkg;

	localparam int SINE_DEPTH   = 256;
	localparam int SINE_AW      = $clog2(SINE_DEPTH);
	localparam int SHAPE_W      = 17;
	localparam int SAMPLE_W     = 16;
	localparam int INDEX_W      = 7;
	localparam int COUNT_W      = 8;
	localparam int MAX_SAMPLES  = 128;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [3:0] {
		WAVE_SINE     = 4'd0,
		WAVE_SQUARE   = 4'd1,
		WAVE_TRIANGLE = 4'd2,
		WAVE_SAWTOOTH = 4'd3
	} wave_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAVE_TYPE    = 3'd0,
		REG_PHASE_STEP   = 3'd1,
		REG_DC_OFFSET    = 3'd2,
		REG_AMPLITUDE    = 3'd3,
		REG_SAMPLE_COUNT = 3'd4
	} cfg_reg_t;

	// Quarter-wave entry round(32768 * sin(pi/2 * k / SINE_DEPTH)) by a
	// nine-term series in Q2.30. Only evaluated at elaboration, where it
	// fills the constant table.
	function automatic logic [SHAPE_W-1:0] sine_entry(int unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned res;
		x    = (HALF_PI_Q30 * 64'(k)) >> SINE_AW;
		x2   = (x * x) >> 30;
		pos  = x;
		neg  = 0;
		term = ((x * x2) / 64'd6) >> 30;
		neg  = neg + term;
		term = ((term * x2) / 64'd20) >> 30;
		pos  = pos + term;
		term = ((term * x2) / 64'd42) >> 30;
		neg  = neg + term;
		term = ((term * x2) / 64'd72) >> 30;
		pos  = pos + term;
		term = ((term * x2) / 64'd110) >> 30;
		neg  = neg + term;
		term = ((term * x2) / 64'd156) >> 30;
		pos  = pos + term;
		term = ((term * x2) / 64'd210) >> 30;
		neg  = neg + term;
		term = ((term * x2) / 64'd272) >> 30;
		pos  = pos + term;
		res  = (pos > neg) ? pos - neg : 64'd0;
		res  = (res + 64'd16384) >> 15;
		if (res > 64'd32768) begin
			res = 64'd32768;
		end
		return SHAPE_W'(res);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/multi_shape_waveform_generator_top.sv -----
// ----------------------------------------------------------------------------
// multi_shape_waveform_generator_top
// Burst waveform generator: sine, square, triangle and sawtooth by DDS.
// ----------------------------------------------------------------------------
// A tick's sample is formed into the stage 1 register once the tick is
// accepted and is offered on the master side from the stage 2 register.
// Throughput: one transaction per clock as long as the sink keeps up;
// back-pressure on m_axis_tready stalls it. arst_n clears the phase, the burst
// counter, all valid flags and the configuration registers (sample count
// returns to 128, everything else to zero).
`timescale 1ns / 1ps
`default_nettype none

module multi_shape_waveform_generator_top
	import mswg_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration write port.
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// Tick stream in.
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [7:0]            s_axis_tdata,   // [0] restart, [7:1] zero
	// Sample stream out.
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [23:0]                m_axis_tdata,   // [15:0] sample_value,
	                                                   // [22:16] sample_index,
	                                                   // [23] zero
	output logic                       m_axis_tlast    // last sample of burst
);

	// ------------------------------------------------------------------
	// Configuration registers. Writes must only happen while the block is
	// idle; the block itself does not enforce this. The pipeline reads them directly.
	// ------------------------------------------------------------------
	logic [3:0]                wave_type_q;
	logic [31:0]               phase_step_q;
	logic signed [SAMPLE_W-1:0] dc_offset_q;
	logic signed [SAMPLE_W-1:0] amplitude_q;
	logic [COUNT_W-1:0]        sample_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_type_q    <= '0;
			phase_step_q   <= '0;
			dc_offset_q    <= '0;
			amplitude_q    <= '0;
			sample_count_q <= COUNT_W'(MAX_SAMPLES);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WAVE_TYPE:    wave_type_q    <= cfg_data[3:0];
				REG_PHASE_STEP:   phase_step_q   <= cfg_data[31:0];
				REG_DC_OFFSET:    dc_offset_q    <= cfg_data[SAMPLE_W-1:0];
				REG_AMPLITUDE:    amplitude_q    <= cfg_data[SAMPLE_W-1:0];
				REG_SAMPLE_COUNT: sample_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake. Stage 2 is the output register; stage 1 holds the shape.
	// Each stage moves when the stage after it is empty or draining, so a
	// new tick is taken every cycle as long as the sink keeps up.
	// ------------------------------------------------------------------
	logic valid_s1;
	logic valid_s2;
	logic adv_s2;
	logic adv_s1;
	logic in_take;

	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;
	assign in_take       = s_axis_tvalid && adv_s1;

	// ------------------------------------------------------------------
	// Phase accumulator and burst counter. A restart zeroes both before the
	// current sample is formed; the last sample of a burst zeroes them after.
	// ------------------------------------------------------------------
	logic [31:0]        phase_q;
	logic [INDEX_W-1:0] burst_cnt_q;
	logic [31:0]        phase_cur;
	logic [INDEX_W-1:0] cnt_cur;
	logic [COUNT_W-1:0] burst_len;
	logic               last_cur;

	always_comb begin
		// A zero count acts as one, anything above the maximum as the maximum.
		if (sample_count_q == '0) begin
			burst_len = COUNT_W'(1);
		end else if (sample_count_q > COUNT_W'(MAX_SAMPLES)) begin
			burst_len = COUNT_W'(MAX_SAMPLES);
		end else begin
			burst_len = sample_count_q;
		end
	end

	assign phase_cur = s_axis_tdata[0] ? '0 : phase_q;
	assign cnt_cur   = s_axis_tdata[0] ? '0 : burst_cnt_q;
	// Lowering the count mid-burst ends the burst at the current sample.
	assign last_cur  = (COUNT_W'(cnt_cur) + COUNT_W'(1)) >= burst_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			burst_cnt_q <= '0;
		end else if (in_take) begin
			if (last_cur) begin
				phase_q     <= '0;
				burst_cnt_q <= '0;
			end else begin
				phase_q     <= phase_cur + phase_step_q;
				burst_cnt_q <= cnt_cur + INDEX_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Shape value in Q1.15 with one extra bit so +1.0 is exactly 32768.
	// ------------------------------------------------------------------
	logic [SHAPE_W-1:0] sine_rom [SINE_DEPTH];

	for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_sine_rom
		localparam logic [SHAPE_W-1:0] ENTRY = sine_entry(g);
		assign sine_rom[g] = ENTRY;
	end

	logic [1:0]               quad;
	logic [SINE_AW-1:0]       sine_k;
	logic [SINE_AW:0]         sine_addr;
	logic [SHAPE_W-1:0]       sine_mag;
	logic [15:0]              phase_u;
	logic signed [SHAPE_W-1:0] shape_cur;

	assign quad      = phase_cur[31:30];
	assign sine_k    = phase_cur[29 -: SINE_AW];
	// Odd quadrants mirror the table; index SINE_DEPTH is the peak itself.
	assign sine_addr = quad[0] ? ((SINE_AW+1)'(SINE_DEPTH) - {1'b0, sine_k})
	                           : {1'b0, sine_k};
	assign sine_mag  = sine_addr[SINE_AW] ? SHAPE_W'(32768)
	                                      : sine_rom[sine_addr[SINE_AW-1:0]];
	assign phase_u   = phase_cur[31:16];

	always_comb begin
		unique case (wave_type_q)
			WAVE_SINE: begin
				shape_cur = quad[1] ? -$signed(sine_mag) : $signed(sine_mag);
			end
			WAVE_SQUARE: begin
				shape_cur = phase_cur[31] ? SHAPE_W'(32768) : -SHAPE_W'(32768);
			end
			WAVE_TRIANGLE: begin
				// 2*|U - 32768| - 32768, folded around the midpoint of the cycle.
				if (phase_u[15]) begin
					shape_cur = $signed({1'b0, phase_u[14:0], 1'b0}) - SHAPE_W'(32768);
				end else begin
					shape_cur = SHAPE_W'(32768) - $signed({1'b0, phase_u[14:0], 1'b0});
				end
			end
			WAVE_SAWTOOTH: begin
				// U - 32768 is U with its top bit flipped, sign-extended by one bit.
				shape_cur = $signed({~phase_u[15], ~phase_u[15], phase_u[14:0]});
			end
			default: begin
				shape_cur = '0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Stage 1: shape, index and burst end.
	// ------------------------------------------------------------------
	logic signed [SHAPE_W-1:0] shape_s1;
	logic [INDEX_W-1:0]        index_s1;
	logic                      last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			shape_s1 <= shape_cur;
			index_s1 <= cnt_cur;
			last_s1  <= last_cur;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: scale by amplitude, round half up, add offset, saturate.
	// ------------------------------------------------------------------
	localparam int PROD_W = SAMPLE_W + SHAPE_W;
	localparam int SUM_W  = 19;

	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   prod_rnd;
	logic signed [SUM_W-1:0]    scaled;
	logic signed [SUM_W-1:0]    sum;
	logic signed [SAMPLE_W-1:0] sample_sat;

	assign prod     = PROD_W'(amplitude_q) * PROD_W'(shape_s1);
	assign prod_rnd = prod + PROD_W'(16384);
	assign scaled   = SUM_W'(prod_rnd >>> 15);
	assign sum      = scaled + SUM_W'(dc_offset_q);

	always_comb begin
		priority if (sum > SUM_W'(32767)) begin
			sample_sat = SAMPLE_W'(32767);
		end else if (sum < -SUM_W'(32768)) begin
			sample_sat = -SAMPLE_W'(32768);
		end else begin
			sample_sat = sum[SAMPLE_W-1:0];
		end
	end

	logic [SAMPLE_W-1:0] value_s2;
	logic [INDEX_W-1:0]  index_s2;
	logic                last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			value_s2 <= sample_sat;
			index_s2 <= index_s1;
			last_s2  <= last_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, index_s2, value_s2};
	assign m_axis_tlast  = last_s2;

endmodule

`default_nettype wire

// ----- rtl/core/mswg_checker.sv -----
// ----------------------------------------------------------------------------
// mswg_checker
// Port-level checks for the waveform generator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mswg_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);

	// A stalled sample must stay offered.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "sample dropped while stalled")

	// No burst is longer than 128 samples, so index 127 always closes it.
	`ASSERT_IMPLIES(a_last_at_max, clk, arst_n, m_axis_tvalid && (m_axis_tdata[22:16] == 7'd127), m_axis_tlast, "index 127 not marked last")

	// The block never refuses a tick while its output side is empty and free.
	`ASSERT_NEXT(a_ready_when_drained, clk, arst_n, !m_axis_tvalid && !s_axis_tvalid, s_axis_tready, "input stalled with empty pipeline")

	// The padding bit of the sample word is always zero.
	`ASSERT_IMPLIES(a_pad_zero, clk, arst_n, m_axis_tvalid, !m_axis_tdata[23], "padding bit set")

endmodule

bind multi_shape_waveform_generator_top mswg_checker u_mswg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- tb/sample_checker.sv -----
// ----------------------------------------------------------------------------
// sample_checker
// Watches the tick and sample streams of the waveform generator, works out
// each expected sample from its own copy of the configuration and the burst
// state, and compares every sample transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sample_checker
	import mswg_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_axis_tvalid,
	input  wire logic                  s_axis_tready,
	input  wire logic [7:0]            s_axis_tdata,
	input  wire logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	input  wire logic [23:0]           m_axis_tdata,
	input  wire logic                  m_axis_tlast,
	output int                         mismatches,
	output int                         outstanding
);

	localparam int  IDX_LO     = SAMPLE_W;
	localparam int  PAD_BIT    = SAMPLE_W + INDEX_W;
	localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
	localparam int  REPORT_MAX = 10;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic [INDEX_W-1:0]  index;
		logic                last;
	} sample_t;

	sample_t expected_samples[$];
	int      quarter_wave[0:SINE_DEPTH];
	int      failures = 0;

	logic [3:0]          wave_sel;
	logic [31:0]         step_reg;
	logic signed [15:0]  offset_reg;
	logic signed [15:0]  gain_reg;
	logic [COUNT_W-1:0]  burst_len_reg;
	logic [31:0]         phase_acc;
	int unsigned         burst_pos;

	// Quarter-wave entry: the sine series summed in Q2.30, rounded to Q1.15.
	function automatic int quarter_sine(int unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned res;
		int              n;
		x    = HALF_PI_Q30 * 64'(k) / 64'(SINE_DEPTH);
		x2   = (x * x) >> 30;
		term = x;
		pos  = x;
		neg  = 0;
		for (n = 1; n <= 8; n++) begin
			term = (term * x2 / 64'((2 * n) * (2 * n + 1))) >> 30;
			if (n % 2 == 1) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		res = (pos > neg) ? pos - neg : 64'd0;
		res = (res + 64'd16384) >> 15;
		return (res > 64'd32768) ? 32768 : int'(res);
	endfunction

	initial begin
		for (int k = 0; k < SINE_DEPTH; k++) begin
			quarter_wave[k] = quarter_sine(k);
		end
		quarter_wave[SINE_DEPTH] = 32768;
	end

	// Shape value at phase p, with +1.0 as 32768.
	function automatic longint shape_at(logic [31:0] p);
		longint unsigned slot;
		int unsigned     quad;
		int unsigned     k;
		longint          v;
		longint          u;
		u = p[31:16];
		u = u - 32768;
		case (wave_sel)
			WAVE_SINE: begin
				slot = (64'(p) * 64'(4 * SINE_DEPTH)) >> 32;
				quad = (slot / SINE_DEPTH) % 4;
				k    = slot % SINE_DEPTH;
				v    = ((quad & 1) != 0) ? quarter_wave[SINE_DEPTH - k] : quarter_wave[k];
				return ((quad & 2) != 0) ? -v : v;
			end
			WAVE_SQUARE:   return (p < 32'h8000_0000) ? -32768 : 32768;
			WAVE_TRIANGLE: return 2 * ((u < 0) ? -u : u) - 32768;
			WAVE_SAWTOOTH: return u;
			default:       return 0;
		endcase
	endfunction

	// One tick of the generator: the sample it yields, then the burst advance.
	function automatic sample_t synthesize(logic restart);
		int unsigned len;
		longint      level;
		sample_t     s;
		len = burst_len_reg;
		if (len < 1) begin
			len = 1;
		end
		if (len > MAX_SAMPLES) begin
			len = MAX_SAMPLES;
		end
		if (restart) begin
			phase_acc = '0;
			burst_pos = 0;
		end
		level = ((longint'(gain_reg) * shape_at(phase_acc) + 16384) >>> 15)
			+ longint'(offset_reg);
		if (level > SAMPLE_MAX) begin
			level = SAMPLE_MAX;
		end
		if (level < SAMPLE_MIN) begin
			level = SAMPLE_MIN;
		end
		s.value = level[SAMPLE_W-1:0];
		s.index = burst_pos[INDEX_W-1:0];
		// A counter at or past the length also ends the burst, which covers a
		// length lowered in the middle of a burst.
		s.last  = (burst_pos + 1 >= len);
		if (s.last) begin
			phase_acc = '0;
			burst_pos = 0;
		end else begin
			phase_acc = phase_acc + step_reg;
			burst_pos = burst_pos + 1;
		end
		return s;
	endfunction

	task automatic flag(input string what);
		failures++;
		if (failures <= REPORT_MAX) begin
			$display("[%0t] %s", $time, what);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sample_t want;
		if (!arst_n) begin
			wave_sel      = 4'd0;
			step_reg      = '0;
			offset_reg    = '0;
			gain_reg      = '0;
			burst_len_reg = COUNT_W'(MAX_SAMPLES);
			phase_acc     = '0;
			burst_pos     = 0;
			failures      = 0;
			expected_samples.delete();
			outstanding <= 0;
			mismatches  <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_samples.size() == 0) begin
					flag($sformatf("unexpected sample: value %0d index %0d last %0b",
						$signed(m_axis_tdata[SAMPLE_W-1:0]),
						m_axis_tdata[PAD_BIT-1:IDX_LO], m_axis_tlast));
				end else begin
					want = expected_samples.pop_front();
					if (m_axis_tdata[SAMPLE_W-1:0] !== want.value
							|| m_axis_tdata[PAD_BIT-1:IDX_LO] !== want.index
							|| m_axis_tlast !== want.last
							|| m_axis_tdata[PAD_BIT] !== 1'b0) begin
						flag($sformatf({"sample mismatch: expected value %0d index %0d ",
							"last %0b, got value %0d index %0d last %0b pad %0b"},
							$signed(want.value), want.index, want.last,
							$signed(m_axis_tdata[SAMPLE_W-1:0]),
							m_axis_tdata[PAD_BIT-1:IDX_LO], m_axis_tlast,
							m_axis_tdata[PAD_BIT]));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_samples.push_back(synthesize(s_axis_tdata[0]));
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_WAVE_TYPE:    wave_sel      = cfg_data[3:0];
					REG_PHASE_STEP:   step_reg      = cfg_data[31:0];
					REG_DC_OFFSET:    offset_reg    = cfg_data[15:0];
					REG_AMPLITUDE:    gain_reg      = cfg_data[15:0];
					REG_SAMPLE_COUNT: burst_len_reg = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			outstanding <= expected_samples.size();
			mismatches  <= failures;
		end
	end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the burst waveform generator: a short directed
// pass over every shape and corner, then randomly configured phases of ticks
// with random stalls on both streams, checked sample by sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import mswg_pkg::*;

	// A long output hold must stay well below the idle limit.
	localparam int LONG_HOLD    = 300;
	localparam int IDLE_LIMIT   = 5000;
	localparam int TICK_TARGET  = 1150;
	// The block answers a tick through its stage 1 and stage 2 registers; this margin covers it.
	localparam int DRAIN_CYCLES = 4;
	localparam int RESET_CYCLES = 11;
	// Wave type codes outside the defined shapes produce only the offset.
	localparam logic [3:0] WAVE_UNKNOWN     = 4'd9;
	localparam logic [3:0] WAVE_UNKNOWN_TOP = 4'd15;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = REG_WAVE_TYPE;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [23:0]           m_axis_tdata;
	logic                  m_axis_tlast;

	int mismatches;
	int outstanding;
	int ticks_sent    = 0;
	int restarts_sent = 0;
	int settings_used = 0;
	int long_holds    = 0;
	int hold_left     = 0;
	int idle_cycles   = 0;

	// Per-phase switches for idling on each side, and the request for one
	// long hold-off of the sample stream.
	bit tx_gaps_on    = 1'b0;
	bit rx_stalls_on  = 1'b0;
	bit long_hold_req = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	multi_shape_waveform_generator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [0] restart, [7:1] zero
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [15:0] sample_value, [22:16] sample_index,
		                                 // [23] zero
		.m_axis_tlast  (m_axis_tlast)
	);

	sample_checker u_sample_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	// Idle stretches drawn from three ranges, the shortest range most often.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99, 0);
		if (r < 80) begin
			return $urandom_range(3, 1);
		end else if (r < 96) begin
			return $urandom_range(12, 4);
		end
		return $urandom_range(60, 20);
	endfunction

	// Offset and amplitude values, with the signed extremes drawn often.
	function automatic logic [15:0] pick_level();
		case ($urandom_range(4, 0))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'($urandom);
			3:       return 16'(int'($urandom_range(2000, 0)) - 1000);
			default: return 16'h0000;
		endcase
	endfunction

	// Phase steps from slow sweeps to aliasing ones; a negative frequency is
	// written as its two's complement.
	function automatic logic [31:0] pick_step();
		case ($urandom_range(5, 0))
			0:       return $urandom;
			1:       return $urandom_range(32'h0100_0000, 1);
			2:       return 32'h1 << $urandom_range(31, 20);
			3:       return 32'h0;
			4:       return 32'hFFFF_FFFF;
			default: return -$urandom_range(32'h0400_0000, 1);
		endcase
	endfunction

	// Starts a register write; the caller lowers cfg_we after the last one so
	// that back-to-back writes keep the enable high.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Offers one tick and returns at the edge where it was accepted.
	task automatic send_tick(input logic restart);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'b0, restart};
		ticks_sent++;
		if (restart) begin
			restarts_sent++;
		end
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
	endtask

	// A run of ticks with a given restart rate in percent. When asked, the
	// receiver is told to hold off halfway through while ticks keep coming.
	task automatic run_ticks(input int n, input int restart_pct, input bit with_hold);
		int i;
		int gap;
		for (i = 0; i < n; i++) begin
			if (with_hold && i == n / 2) begin
				long_hold_req = 1'b1;
			end
			send_tick($urandom_range(99, 0) < restart_pct);
			if (tx_gaps_on && $urandom_range(3, 0) == 0) begin
				gap = pick_gap();
				s_axis_tvalid <= 1'b0;
				s_axis_tdata  <= {7'b0, 1'($urandom)};
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stops the tick stream and waits until every expected sample has come
	// back, plus DRAIN_CYCLES more so the pipeline is empty before any write.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// A fresh random setting; registers left alone keep their old value, and
	// the burst state carries over so shorter bursts cut in mid-burst.
	task automatic random_settings();
		int r;
		if ($urandom_range(3, 0) != 0) begin
			if ($urandom_range(3, 0) != 0) begin
				write_reg(REG_WAVE_TYPE, 32'($urandom_range(3, 0)));
			end else begin
				write_reg(REG_WAVE_TYPE, 32'($urandom_range(15, 4)));
			end
		end
		if ($urandom_range(3, 0) != 0) begin
			write_reg(REG_PHASE_STEP, pick_step());
		end
		if ($urandom_range(3, 0) != 0) begin
			write_reg(REG_DC_OFFSET, {16'h0, pick_level()});
		end
		if ($urandom_range(3, 0) != 0) begin
			write_reg(REG_AMPLITUDE, {16'h0, pick_level()});
		end
		if ($urandom_range(3, 0) != 0) begin
			r = $urandom_range(9, 0);
			if (r < 8) begin
				write_reg(REG_SAMPLE_COUNT, 32'($urandom_range(40, 1)));
			end else if (r == 8) begin
				write_reg(REG_SAMPLE_COUNT, 32'($urandom_range(MAX_SAMPLES, 41)));
			end else begin
				write_reg(REG_SAMPLE_COUNT, 32'($urandom_range(255, 0)));
			end
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Sample-side ready: random short and long stalls when enabled, and one
	// long hold-off on request, counted here in cycles.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				long_holds++;
				hold_left = LONG_HOLD - 1;
				m_axis_tready <= 1'b0;
			end else if (rx_stalls_on && $urandom_range(7, 0) == 0) begin
				hold_left = pick_gap() - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run if no transaction moves on either stream for
	// too long.
	initial begin
		wait (arst_n === 1'b1);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int n;
		int phase_no;
		int pct;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: zero amplitude and offset, so every sample is zero.
		send_tick(1'b0);
		send_tick(1'b1);
		drain();

		// Sine at an eighth of a turn per sample over an eight-sample burst
		// hits every quadrant, including the full-scale table entry. The most
		// negative amplitude with the top offset saturates the high side.
		write_reg(REG_WAVE_TYPE, 32'(WAVE_SINE));
		write_reg(REG_PHASE_STEP, 32'h2000_0000);
		write_reg(REG_DC_OFFSET, 32'h0000_7FFF);
		write_reg(REG_AMPLITUDE, 32'h0000_8000);
		write_reg(REG_SAMPLE_COUNT, 32'd8);
		cfg_we <= 1'b0;
		send_tick(1'b1);
		run_ticks(7, 0, 1'b0);
		drain();

		// Square at half a turn per sample with a one-sample burst: every
		// sample is last and the low side saturates.
		write_reg(REG_WAVE_TYPE, 32'(WAVE_SQUARE));
		write_reg(REG_PHASE_STEP, 32'h8000_0000);
		write_reg(REG_DC_OFFSET, 32'h0000_8000);
		write_reg(REG_AMPLITUDE, 32'h0000_7FFF);
		write_reg(REG_SAMPLE_COUNT, 32'd1);
		cfg_we <= 1'b0;
		run_ticks(3, 0, 1'b0);
		drain();

		// Triangle with the largest step; a count above the maximum acts as
		// the maximum, so these ticks leave the burst counter mid-way.
		write_reg(REG_WAVE_TYPE, 32'(WAVE_TRIANGLE));
		write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
		write_reg(REG_DC_OFFSET, 32'h0000_0000);
		write_reg(REG_SAMPLE_COUNT, 32'd255);
		cfg_we <= 1'b0;
		run_ticks(3, 0, 1'b0);
		drain();

		// Sawtooth with the burst shortened below the running counter: the
		// first sample is marked last and the burst wraps; a restart follows.
		write_reg(REG_WAVE_TYPE, 32'(WAVE_SAWTOOTH));
		write_reg(REG_PHASE_STEP, $urandom);
		write_reg(REG_DC_OFFSET, {16'h0, 16'($urandom)});
		write_reg(REG_AMPLITUDE, {16'h0, 16'($urandom)});
		write_reg(REG_SAMPLE_COUNT, 32'd2);
		cfg_we <= 1'b0;
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		drain();

		// Unknown wave types give the offset alone; a zero count acts as one.
		write_reg(REG_WAVE_TYPE, 32'(WAVE_UNKNOWN));
		write_reg(REG_DC_OFFSET, 32'h0000_8000);
		write_reg(REG_SAMPLE_COUNT, 32'd0);
		cfg_we <= 1'b0;
		run_ticks(2, 0, 1'b0);
		drain();
		write_reg(REG_WAVE_TYPE, 32'(WAVE_UNKNOWN_TOP));
		cfg_we <= 1'b0;
		send_tick(1'b1);
		drain();
		settings_used = 7;

		// Random phases. Each one ends by draining, so the sender pauses until
		// every sample is back before the next setting. One early phase runs
		// without sender gaps while the receiver holds off for a long stretch,
		// so the block fills and stalls the tick stream.
		phase_no = 0;
		while (ticks_sent < TICK_TARGET) begin
			random_settings();
			tx_gaps_on   = ($urandom_range(9, 0) < 7);
			rx_stalls_on = ($urandom_range(9, 0) < 7);
			if (phase_no == 2) begin
				tx_gaps_on = 1'b0;
			end
			case ($urandom_range(3, 0))
				0:       pct = 0;
				1:       pct = 3;
				2:       pct = 10;
				default: pct = 40;
			endcase
			n = $urandom_range(90, 10);
			run_ticks(n, pct, phase_no == 2);
			drain();
			phase_no++;
		end

		$display("Drove %0d ticks (%0d with restart) through %0d register settings,",
			ticks_sent, restarts_sent, settings_used);
		$display("covering all shapes, unknown types, burst limits and %0d long output hold(s).",
			long_holds);
		if (mismatches == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/mswg_pkg.sv
rtl/core/multi_shape_waveform_generator_top.sv
rtl/core/mswg_checker.sv
tb/sample_checker.sv
tb/tb.sv
